/* src/tcw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   // Field widths
   localparam int FUNC_W = 2;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = 16;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE    = 8'h0A;
   localparam logic [CHAR_W-1:0] BLANK_CODE      = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_ATTRIBUTE = 8'h0F;

   // Command queue between front and back
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [ADDR_W:0]   addr_sum_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUT   = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      OP_PUT,
      OP_NEWLINE,
      OP_READ,
      OP_REPORT,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CHAR_W-1:0]   char_code;
      addr_type            addr;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_ROW,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic pop;
      logic init;
   } back_ctl_type;

   // Row-major cell index of a row and column
   function automatic addr_type logical_addr(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

   // Rotate a logical cell index by the address of the top row
   function automatic addr_type phys_addr(addr_type logical, addr_type base);
      addr_sum_type sum;
      sum = {1'b0, logical} + {1'b0, base};
      if (sum >= addr_sum_type'(CELL_COUNT)) begin
         sum = sum - addr_sum_type'(CELL_COUNT);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* src/tcw_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_front (
   input  wire logic [tcw_pkg::FUNC_W-1:0] func,
   input  wire logic [tcw_pkg::CHAR_W-1:0] char_code,
   input  wire logic [tcw_pkg::ROW_W-1:0]  read_row,
   input  wire logic [tcw_pkg::COL_W-1:0]  read_column,
   output tcw_pkg::cmd_type                cmd
);

   logic read_in_range;

   assign read_in_range = (int'(read_row) < tcw_pkg::ROWS) &&
                          (int'(read_column) < tcw_pkg::COLUMNS);

   always_comb begin
      cmd.char_code = char_code;
      cmd.addr      = tcw_pkg::logical_addr(read_row, read_column);
      case (tcw_pkg::func_type'(func))
         tcw_pkg::FUNC_PUT: begin
            cmd.op = (char_code == tcw_pkg::NEWLINE_CODE) ? tcw_pkg::OP_NEWLINE
                                                          : tcw_pkg::OP_PUT;
         end
         tcw_pkg::FUNC_READ: begin
            // off-screen reads just report zero
            cmd.op = read_in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_REPORT;
         end
         tcw_pkg::FUNC_CLEAR: begin
            cmd.op = tcw_pkg::OP_CLEAR;
         end
         default: begin
            cmd.op = tcw_pkg::OP_REPORT;
         end
      endcase
   end

endmodule

`default_nettype wire

/* src/tcw_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire tcw_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output tcw_pkg::cmd_type      head_cmd,
   output logic                  full,
   output logic                  empty
);

   tcw_pkg::cmd_type                  entries_ff [tcw_pkg::FIFO_DEPTH];
   logic [tcw_pkg::FIFO_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tcw_pkg::FIFO_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tcw_pkg::FIFO_CNT_W-1:0]    count_ff, count_in;

   function automatic logic [tcw_pkg::FIFO_PTR_W-1:0] bump(
      logic [tcw_pkg::FIFO_PTR_W-1:0] ptr);
      return (ptr == tcw_pkg::FIFO_PTR_W'(tcw_pkg::FIFO_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign full     = (count_ff == tcw_pkg::FIFO_CNT_W'(tcw_pkg::FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("command queue popped while empty");
`endif

endmodule

`default_nettype wire

/* src/tcw_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [tcw_pkg::ATTR_W-1:0] attr,
   input  wire tcw_pkg::cmd_type           cmd,
   input  wire logic                       fifo_empty,
   output tcw_pkg::back_ctl_type           ctl,
   output logic                            rsp_strobe,
   output logic [tcw_pkg::CELL_W-1:0]      rsp_cell_value,
   output logic [tcw_pkg::ROW_W-1:0]       rsp_row_pos,
   output logic [tcw_pkg::COL_W-1:0]       rsp_col_pos
);

   tcw_pkg::state_type               state_ff, state_in;
   logic [tcw_pkg::ROW_W-1:0]        row_pos_ff, row_pos_in;
   logic [tcw_pkg::COL_W-1:0]        col_pos_ff, col_pos_in;
   tcw_pkg::addr_type                base_ff, base_in;
   tcw_pkg::addr_type                sweep_addr_ff, sweep_addr_in;
   tcw_pkg::addr_type                sweep_last_ff, sweep_last_in;
   logic                             rsp_strobe_ff, rsp_strobe_in;
   logic [tcw_pkg::CELL_W-1:0]       rsp_cell_ff, rsp_cell_in;
   logic [tcw_pkg::CELL_W-1:0]       rd_data_ff;

   logic [tcw_pkg::CELL_W-1:0]       screen_mem [tcw_pkg::CELL_COUNT];

   logic                             mem_we;
   tcw_pkg::addr_type                mem_waddr;
   logic [tcw_pkg::CELL_W-1:0]       mem_wdata;
   logic                             mem_re;
   tcw_pkg::addr_type                mem_raddr;

   tcw_pkg::addr_type                cur_phys;
   tcw_pkg::addr_type                next_row_phys;
   tcw_pkg::addr_type                base_scrolled;
   logic [tcw_pkg::ATTR_W-1:0]       blank_attr;
   logic                             last_row;
   logic                             last_col;
   logic                             sweep_done;

   assign cur_phys      = tcw_pkg::phys_addr(
                             tcw_pkg::logical_addr(row_pos_ff, col_pos_ff), base_ff);
   assign next_row_phys = tcw_pkg::phys_addr(
                             tcw_pkg::logical_addr(row_pos_ff + 1'b1, '0), base_ff);
   assign base_scrolled = (base_ff == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS))
                          ? '0 : base_ff + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
   assign last_row      = (row_pos_ff == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
   assign last_col      = (col_pos_ff == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
   assign sweep_done    = (sweep_addr_ff == sweep_last_ff);
   // the power-up fill always uses the reset attribute
   assign blank_attr    = (state_ff == tcw_pkg::ST_INIT) ? tcw_pkg::RESET_ATTRIBUTE : attr;

   always_comb begin
      state_in         = state_ff;
      row_pos_in       = row_pos_ff;
      col_pos_in       = col_pos_ff;
      base_in          = base_ff;
      sweep_addr_in    = sweep_addr_ff;
      sweep_last_in    = sweep_last_ff;
      rsp_strobe_in    = 1'b0;
      rsp_cell_in      = rsp_cell_ff;
      ctl.pop          = 1'b0;
      ctl.init         = (state_ff == tcw_pkg::ST_INIT);
      mem_we           = 1'b0;
      mem_waddr        = sweep_addr_ff;
      mem_wdata        = {blank_attr, tcw_pkg::BLANK_CODE};
      mem_re           = 1'b0;
      mem_raddr        = tcw_pkg::phys_addr(cmd.addr, base_ff);

      case (state_ff)
         tcw_pkg::ST_INIT: begin
            mem_we = 1'b1;
            if (sweep_done) begin
               state_in = tcw_pkg::ST_IDLE;
            end else begin
               sweep_addr_in = sweep_addr_ff + 1'b1;
            end
         end

         tcw_pkg::ST_IDLE: begin
            if (!fifo_empty) begin
               ctl.pop = 1'b1;
               case (cmd.op)
                  tcw_pkg::OP_PUT: begin
                     mem_we    = 1'b1;
                     mem_waddr = cur_phys;
                     mem_wdata = {attr, cmd.char_code};
                     if (!last_col) begin
                        col_pos_in    = col_pos_ff + 1'b1;
                        rsp_strobe_in = 1'b1;
                        rsp_cell_in   = '0;
                     end else if (!last_row) begin
                        col_pos_in    = '0;
                        row_pos_in    = row_pos_ff + 1'b1;
                        rsp_strobe_in = 1'b1;
                        rsp_cell_in   = '0;
                     end else begin
                        // wrap off the bottom: scroll and blank the old top row
                        col_pos_in    = '0;
                        base_in       = base_scrolled;
                        sweep_addr_in = base_ff;
                        sweep_last_in = base_ff + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS - 1);
                        state_in      = tcw_pkg::ST_ROW;
                     end
                  end
                  tcw_pkg::OP_NEWLINE: begin
                     col_pos_in = '0;
                     state_in   = tcw_pkg::ST_ROW;
                     if (last_row) begin
                        base_in       = base_scrolled;
                        sweep_addr_in = base_ff;
                        sweep_last_in = base_ff + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS - 1);
                     end else begin
                        row_pos_in    = row_pos_ff + 1'b1;
                        sweep_addr_in = next_row_phys;
                        sweep_last_in = next_row_phys + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS - 1);
                     end
                  end
                  tcw_pkg::OP_READ: begin
                     mem_re   = 1'b1;
                     state_in = tcw_pkg::ST_READ;
                  end
                  tcw_pkg::OP_CLEAR: begin
                     row_pos_in    = '0;
                     col_pos_in    = '0;
                     base_in       = '0;
                     sweep_addr_in = '0;
                     sweep_last_in = tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);
                     state_in      = tcw_pkg::ST_CLEAR;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_cell_in   = '0;
                  end
               endcase
            end
         end

         tcw_pkg::ST_READ: begin
            rsp_strobe_in = 1'b1;
            rsp_cell_in   = rd_data_ff;
            state_in      = tcw_pkg::ST_IDLE;
         end

         tcw_pkg::ST_ROW, tcw_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            if (sweep_done) begin
               rsp_strobe_in = 1'b1;
               rsp_cell_in   = '0;
               state_in      = tcw_pkg::ST_IDLE;
            end else begin
               sweep_addr_in = sweep_addr_ff + 1'b1;
            end
         end

         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tcw_pkg::ST_INIT;
         row_pos_ff    <= '0;
         col_pos_ff    <= '0;
         base_ff       <= '0;
         sweep_addr_ff <= '0;
         sweep_last_ff <= tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_pos_ff    <= row_pos_in;
         col_pos_ff    <= col_pos_in;
         base_ff       <= base_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_last_ff <= sweep_last_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cell_ff <= rsp_cell_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= screen_mem[mem_raddr];
      end
   end

   // cursor registers only move on a pop, which ends the strobe cycle
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_row_pos    = row_pos_ff;
   assign rsp_col_pos    = col_pos_ff;

`ifndef ASSERT_OFF
   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      (int'(row_pos_ff) < tcw_pkg::ROWS) && (int'(col_pos_ff) < tcw_pkg::COLUMNS))
      else $error("cursor left the screen");
   a_base_row_aligned: assert property (@(posedge clock) disable iff (reset)
      (int'(base_ff) <= tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS) &&
      (int'(sweep_last_ff) < tcw_pkg::CELL_COUNT))
      else $error("top row address out of range");
   a_sweep_ends_in_result: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == tcw_pkg::ST_ROW || state_ff == tcw_pkg::ST_CLEAR) && sweep_done)
      |=> (rsp_strobe_ff && state_ff == tcw_pkg::ST_IDLE))
      else $error("blanking sweep finished without a result");
`endif

endmodule

`default_nettype wire

/* src/text_console_writer_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Ports                                      | Transfer
// ----------+--------------------------------------------+----------------------------------
// request   | start, busy, req_func, req_char_code,      | edge with start high, busy low
//           | req_read_row, req_read_column              |
// result    | rsp_strobe, rsp_cell_value,                | one cycle with rsp_strobe high
//           | rsp_cursor_row_out, rsp_cursor_column_out  |
// register  | psel, penable, pwrite, paddr, pwdata,      | psel, penable, pwrite, pready high
//           | prdata, pready                             |
//
// Requests land in a two-entry command queue; the back end drains it one command at a time.
// Plain put, off-screen read and unused func are answered straight from the idle state; a read
// goes through the registered screen RAM port and the read state. Newline and put-with-scroll
// make one RAM write per cell of the blanked row, and clear one per cell of the screen, all on
// the single RAM write port. Scrolling rotates the top-row address instead of copying cells.
// After reset the back end fills the screen RAM with blanks; busy stays high meanwhile.
// Results cannot be stalled; beyond reset and that fill, busy rises only when the queue fills.

module text_console_writer_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [tcw_pkg::FUNC_W-1:0] req_func,
   input  wire logic [tcw_pkg::CHAR_W-1:0] req_char_code,
   input  wire logic [tcw_pkg::ROW_W-1:0]  req_read_row,
   input  wire logic [tcw_pkg::COL_W-1:0]  req_read_column,
   // result channel
   output logic                            rsp_strobe,
   output logic [tcw_pkg::CELL_W-1:0]      rsp_cell_value,
   output logic [tcw_pkg::ROW_W-1:0]       rsp_cursor_row_out,
   output logic [tcw_pkg::COL_W-1:0]       rsp_cursor_column_out,
   // register port
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [2:0]                 paddr,
   input  wire logic [31:0]                pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   // word index of the attribute register
   localparam logic [0:0] REG_TEXT_ATTRIBUTE = 1'b0;

   logic [tcw_pkg::ATTR_W-1:0] text_attribute_ff, text_attribute_in;
   logic                       csr_write;
   logic                       req_transfer;
   tcw_pkg::cmd_type           front_cmd;
   tcw_pkg::cmd_type           head_cmd;
   logic                       fifo_full;
   logic                       fifo_empty;
   tcw_pkg::back_ctl_type      back_ctl;

   // ---------------------------------------------------------------
   // Register port: no wait states, attribute at word 0
   // ---------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      text_attribute_in = text_attribute_ff;
      if (csr_write && (paddr[2:2] == REG_TEXT_ATTRIBUTE)) begin
         text_attribute_in = pwdata[tcw_pkg::ATTR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_attribute_ff <= tcw_pkg::RESET_ATTRIBUTE;
      end else begin
         text_attribute_ff <= text_attribute_in;
      end
   end

   assign prdata = (paddr[2:2] == REG_TEXT_ATTRIBUTE)
                   ? {{(32 - tcw_pkg::ATTR_W){1'b0}}, text_attribute_ff} : '0;

   // ---------------------------------------------------------------
   // Front: decode the request, hold off while the queue is full or
   // the screen is still being filled after reset
   // ---------------------------------------------------------------
   assign busy         = reset || fifo_full || back_ctl.init;
   assign req_transfer = start && !busy;

   tcw_front u_front (
      .func        (req_func),
      .char_code   (req_char_code),
      .read_row    (req_read_row),
      .read_column (req_read_column),
      .cmd         (front_cmd)
   );

   tcw_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (req_transfer),
      .push_cmd (front_cmd),
      .pop      (back_ctl.pop),
      .head_cmd (head_cmd),
      .full     (fifo_full),
      .empty    (fifo_empty)
   );

   // ---------------------------------------------------------------
   // Back: screen RAM, cursor and the result register
   // ---------------------------------------------------------------
   tcw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .attr           (text_attribute_ff),
      .cmd            (head_cmd),
      .fifo_empty     (fifo_empty),
      .ctl            (back_ctl),
      .rsp_strobe     (rsp_strobe),
      .rsp_cell_value (rsp_cell_value),
      .rsp_row_pos    (rsp_cursor_row_out),
      .rsp_col_pos    (rsp_cursor_column_out)
   );

endmodule

`default_nettype wire

/* dv/text_console_writer_core_tb.sv */
`timescale 1ns / 1ps

module text_console_writer_core_tb;
   import tcw_pkg::*;

   // Register map: text_attribute is the only register, at byte address 0.
   localparam int               ATTR_REG_INDEX = 0;
   localparam logic [2:0]       ATTR_REG_ADDR  = 3'(4 * ATTR_REG_INDEX);
   localparam int               MAX_REPORTS    = 10;
   // Longest back-end job is a full clear; settle past it.
   localparam int               SETTLE_CYCLES  = CELL_COUNT + 100;
   localparam int               PHASE_ITEMS    = 600;

   typedef struct packed {
      func_type            func;
      logic [CHAR_W-1:0]   char_code;
      logic [ROW_W-1:0]    read_row;
      logic [COL_W-1:0]    read_column;
   } console_request_t;

   typedef struct packed {
      logic [CELL_W-1:0]   cell_bits;
      logic [ROW_W-1:0]    pos_row;
      logic [COL_W-1:0]    pos_col;
   } console_result_t;

   // DUT signals; every input starts at a known value
   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                start           = 1'b0;
   logic                busy;
   logic [FUNC_W-1:0]   req_func        = '0;
   logic [CHAR_W-1:0]   req_char_code   = '0;
   logic [ROW_W-1:0]    req_read_row    = '0;
   logic [COL_W-1:0]    req_read_column = '0;
   logic                rsp_strobe;
   logic [CELL_W-1:0]   rsp_cell_value;
   logic [ROW_W-1:0]    rsp_cursor_row_out;
   logic [COL_W-1:0]    rsp_cursor_column_out;
   logic                psel            = 1'b0;
   logic                penable         = 1'b0;
   logic                pwrite          = 1'b0;
   logic [2:0]          paddr           = '0;
   logic [31:0]         pwdata          = '0;
   logic [31:0]         prdata;
   logic                pready;

   // Requests waiting to be transferred, and results owed by the DUT
   console_request_t    pending_requests[$];
   console_result_t     owed_results[$];

   // Shadow of the console: screen, cursor, attribute register
   logic [CELL_W-1:0]   screen_shadow [0:CELL_COUNT-1];
   logic [ROW_W-1:0]    shadow_row;
   logic [COL_W-1:0]    shadow_column;
   logic [ATTR_W-1:0]   attribute_shadow = RESET_ATTRIBUTE;

   int                  sender_idle_pct = 12;
   int                  error_count     = 0;
   int                  items_queued    = 0;
   int                  transfers_done  = 0;
   int                  results_checked = 0;
   int                  puts_seen       = 0;
   int                  newlines_seen   = 0;
   int                  reads_seen      = 0;
   int                  clears_seen     = 0;
   int                  scrolls_seen    = 0;
   longint              cycle_count     = 0;
   longint              cycle_limit     = 4 * (CELL_COUNT + SETTLE_CYCLES + 1000);

   text_console_writer_core u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_func              (req_func),
      .req_char_code         (req_char_code),
      .req_read_row          (req_read_row),
      .req_read_column       (req_read_column),
      .rsp_strobe            (rsp_strobe),
      .rsp_cell_value        (rsp_cell_value),
      .rsp_cursor_row_out    (rsp_cursor_row_out),
      .rsp_cursor_column_out (rsp_cursor_column_out),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Console shadow
   // ------------------------------------------------------------------

   function automatic logic [CELL_W-1:0] blank_cell_bits();
      return {attribute_shadow, BLANK_CODE};
   endfunction

   function automatic void blank_shadow_row(int row);
      if (row < ROWS) begin
         for (int c = 0; c < COLUMNS; c++) begin
            screen_shadow[row * COLUMNS + c] = blank_cell_bits();
         end
      end
   endfunction

   // Shift every row up by one, blank the bottom row, pull the cursor up.
   function automatic void scroll_shadow_up();
      for (int i = COLUMNS; i < CELL_COUNT; i++) begin
         screen_shadow[i - COLUMNS] = screen_shadow[i];
      end
      blank_shadow_row(ROWS - 1);
      if (shadow_row > 0) shadow_row = shadow_row - 1'b1;
      scrolls_seen++;
   endfunction

   function automatic void clear_shadow_screen();
      for (int r = 0; r < ROWS; r++) blank_shadow_row(r);
      shadow_row    = '0;
      shadow_column = '0;
   endfunction

   function automatic void put_shadow_char(logic [CHAR_W-1:0] code);
      if (code == NEWLINE_CODE) begin
         // Newline: column 0 of the next row, which gets blanked
         newlines_seen++;
         shadow_column = '0;
         shadow_row    = shadow_row + 1'b1;
         if (shadow_row >= ROWS) scroll_shadow_up();
         blank_shadow_row(int'(shadow_row));
      end else begin
         puts_seen++;
         screen_shadow[int'(shadow_row) * COLUMNS + int'(shadow_column)] =
            {attribute_shadow, code};
         shadow_column = shadow_column + 1'b1;
         if (shadow_column >= COLUMNS) begin
            shadow_column = '0;
            shadow_row    = shadow_row + 1'b1;
         end
         if (shadow_row >= ROWS) scroll_shadow_up();
      end
   endfunction

   // Apply one transferred request to the shadow and return what the DUT owes.
   function automatic console_result_t apply_console_request(console_request_t item);
      console_result_t outcome;
      outcome.cell_bits = '0;
      case (item.func)
         FUNC_PUT: begin
            put_shadow_char(item.char_code);
         end
         FUNC_READ: begin
            reads_seen++;
            if (item.read_row < ROWS && item.read_column < COLUMNS) begin
               outcome.cell_bits =
                  screen_shadow[int'(item.read_row) * COLUMNS + int'(item.read_column)];
            end
         end
         FUNC_CLEAR: begin
            clears_seen++;
            clear_shadow_screen();
         end
         default: ;
      endcase
      outcome.pos_row = shadow_row;
      outcome.pos_col = shadow_column;
      return outcome;
   endfunction

   function automatic void note_failure(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%s", msg);
   endfunction

   // ------------------------------------------------------------------
   // Request driver: present the head of pending_requests, drop it and
   // predict its result on the edge that completes the transfer.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      console_result_t predicted;
      if (reset) begin
         start <= 1'b0;
         clear_shadow_screen();
      end else begin
         if (start && !busy) begin
            predicted = apply_console_request(pending_requests.pop_front());
            owed_results.push_back(predicted);
            transfers_done++;
         end
         // Hold the current request while busy; otherwise pick the next or idle.
         if (!start || !busy) begin
            if (pending_requests.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct) begin
               start           <= 1'b1;
               req_func        <= pending_requests[0].func;
               req_char_code   <= pending_requests[0].char_code;
               req_read_row    <= pending_requests[0].read_row;
               req_read_column <= pending_requests[0].read_column;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: track register transfers, check every result strobe.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      console_result_t wanted;
      if (!reset) begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr == ATTR_REG_ADDR) attribute_shadow <= pwdata[ATTR_W-1:0];
            end else if (prdata[ATTR_W-1:0] !== attribute_shadow) begin
               note_failure($sformatf("attribute readback: expected %02h, got %02h",
                                      attribute_shadow, prdata[ATTR_W-1:0]));
            end
         end
         if (rsp_strobe) begin
            if (owed_results.size() == 0) begin
               note_failure($sformatf("unexpected result: cell %04h row %0d col %0d",
                                      rsp_cell_value, rsp_cursor_row_out,
                                      rsp_cursor_column_out));
            end else begin
               wanted = owed_results.pop_front();
               results_checked++;
               if (rsp_cell_value        !== wanted.cell_bits ||
                   rsp_cursor_row_out    !== wanted.pos_row   ||
                   rsp_cursor_column_out !== wanted.pos_col) begin
                  note_failure($sformatf(
                     "result %0d: expected cell %04h row %0d col %0d, got cell %04h row %0d col %0d",
                     results_checked, wanted.cell_bits, wanted.pos_row,
                     wanted.pos_col, rsp_cell_value, rsp_cursor_row_out,
                     rsp_cursor_column_out));
               end
            end
         end
      end
   end

   // Watchdog: the limit grows with every queued request.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, owed_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   task automatic push_request(input func_type func, input logic [CHAR_W-1:0] code,
                               input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
      console_request_t item;
      int               cost;
      item = '{func: func, char_code: code, read_row: row, read_column: col};
      pending_requests.push_back(item);
      items_queued++;
      // Budget for sender gaps plus the back end's own work on this item
      cost = (func == FUNC_CLEAR) ? CELL_COUNT + 100 : (func == FUNC_PUT) ? COLUMNS + 20 : 10;
      cycle_limit += 4 * (60 + cost);
   endtask

   task automatic push_put(input logic [CHAR_W-1:0] code);
      push_request(FUNC_PUT, code, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
   endtask

   task automatic push_read(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
      push_request(FUNC_READ, 8'($urandom_range(0, 255)), row, col);
   endtask

   // Wait until every request is transferred and answered, then let the back end settle.
   task automatic wait_until_quiet();
      while (pending_requests.size() != 0 || owed_results.size() != 0) @(posedge clock);
      cycle_limit += 4 * SETTLE_CYCLES;
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write text_attribute (junk in the unused upper bits), then read it back.
   task automatic write_text_attribute(input logic [ATTR_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ATTR_REG_ADDR;
      pwdata  <= {24'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Random traffic made of bursts: text lines, runs of blank lines, reads,
   // raw noise on every field, and the occasional clear.
   task automatic queue_random_traffic(input int count);
      int                stop_at;
      int                kind;
      int                len;
      logic [CHAR_W-1:0] code;
      stop_at = items_queued + count;
      while (items_queued < stop_at) begin
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            // Mostly short lines; some long enough to wrap past the last column
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 170)
                                              : $urandom_range(0, 40);
            repeat (len) begin
               code = 8'($urandom_range(0, 255));
               if (code == NEWLINE_CODE) code = BLANK_CODE;
               push_put(code);
            end
            if ($urandom_range(0, 4) != 0) push_put(NEWLINE_CODE);
         end else if (kind < 65) begin
            // Runs of newlines push the cursor down to the bottom and scroll
            repeat ($urandom_range(1, 30)) push_put(NEWLINE_CODE);
         end else if (kind < 85) begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 99) < 85)
                  push_read(5'($urandom_range(0, ROWS - 1)),
                            7'($urandom_range(0, COLUMNS - 1)));
               else
                  push_read(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
            end
         end else if (kind < 97) begin
            repeat ($urandom_range(1, 4)) begin
               push_request(func_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                            5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
            end
         end else begin
            push_request(FUNC_CLEAR, 8'($urandom_range(0, 255)),
                         5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset attribute. The DUT clears its RAM after
      // reset with busy high; the driver just waits on the handshake.
      sender_idle_pct = 12;
      push_read(5'd0, 7'd0);                  // blank cell after reset
      push_read(5'(ROWS - 1), 7'(COLUMNS - 1));
      push_read(5'(ROWS), 7'd0);              // row just off the screen
      push_read(5'd0, 7'(COLUMNS));           // column just off the screen
      push_read(5'd31, 7'd127);               // all ones
      push_request(FUNC_READ, 8'hFF, 5'd2, 7'd3);
      push_request(FUNC_NONE, 8'hFF, 5'd31, 7'd127);  // unused func: nothing moves
      push_put(8'h00);
      push_put(8'hFF);
      push_put(8'h80);                        // high bit set: stays unsigned
      push_put(8'h41);
      push_read(5'd0, 7'd1);
      push_read(5'd0, 7'd2);
      push_put(NEWLINE_CODE);
      push_read(5'd1, 7'd0);
      push_put(8'h7F);
      push_request(FUNC_CLEAR, 8'hFF, 5'd31, 7'd127);
      push_read(5'd0, 7'd0);
      push_read(5'd1, 7'd0);
      push_put(BLANK_CODE);
      wait_until_quiet();

      // Attribute all ones, sender idles now and then
      write_text_attribute(8'hFF);
      queue_random_traffic(PHASE_ITEMS);
      wait_until_quiet();

      // Attribute zero, sender idles most of the time
      write_text_attribute(8'h00);
      sender_idle_pct = 83;
      queue_random_traffic(PHASE_ITEMS);
      wait_until_quiet();

      // Random attribute, back-to-back requests
      write_text_attribute(8'($urandom_range(1, 254)));
      sender_idle_pct = 0;
      queue_random_traffic(PHASE_ITEMS);
      wait_until_quiet();

      $display("%0d requests transferred, %0d results checked in %0d cycles",
               transfers_done, results_checked, cycle_count);
      $display("%0d chars, %0d newlines, %0d reads, %0d clears, %0d scrolls",
               puts_seen, newlines_seen, reads_seen, clears_seen, scrolls_seen);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d failures", error_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
